// File: design/uvp_pkg.sv
// ----------------------------------------------------------------------------
// uvp_pkg: shared types and constants for the UUID text parser
// Holds the classified character record passed from the front end to the
// back end, the result status codes and the character codes that are checked.
// ----------------------------------------------------------------------------
`default_nettype none

package uvp_pkg;

  // Text geometry.
  localparam int unsigned TextLen   = 36;
  localparam int unsigned PosSat    = 37;
  localparam int unsigned PosW      = 6;

  // Hyphen positions of the canonical form.
  localparam logic [PosW-1:0] DashPos0 = 6'd8;
  localparam logic [PosW-1:0] DashPos1 = 6'd13;
  localparam logic [PosW-1:0] DashPos2 = 6'd18;
  localparam logic [PosW-1:0] DashPos3 = 6'd23;

  // Character codes.
  localparam logic [7:0] ChDash    = 8'h2D;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChLowA    = 8'h61;
  localparam logic [7:0] ChLowF    = 8'h66;

  // Version and variant fields.
  localparam logic [3:0] VersionFour = 4'h4;
  localparam logic [1:0] VariantRfc  = 2'b10;

  // Queue between front and back end.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FORMAT  = 2'd1,
    STATUS_BAD_HEX = 2'd2,
    STATUS_NOT_V4  = 2'd3
  } status_e;

  // One classified character.
  typedef struct packed {
    logic       shift;      // hex slot: shift the nibble in
    logic [3:0] nibble;     // decoded nibble, zero when not a hex digit
    logic       hex_bad;    // hex slot held something other than a lowercase digit
    logic       dash_bad;   // hyphen slot held something other than a hyphen
    logic       last;       // final character of the text
    logic       len_ok;     // this character is the 36th
  } item_t;

endpackage

`default_nettype wire

// File: design/uuid_v4_text_parser_core.sv
// ----------------------------------------------------------------------------
// uuid_v4_text_parser_core: streaming parser for lowercase version 4 UUID text
// Takes one ASCII character per transaction on the input channel; the
// transaction with last_char_i set closes the text and yields one result
// transaction carrying the 128-bit value and a status.
//
// Input channel: in_valid_i / in_ready_o with character_i and last_char_i.
// Output channel: out_valid_o / out_ready_i with uuid_high_o, uuid_low_o and
// status_o. On any status other than ok, both value halves are zero.
// Throughput: one character per cycle while in_ready_o is high. The final
// character's entry is written into the queue, then taken by the back end
// into the output register, where the result is presented.
// When the receiver stalls, the result is held in the output register and
// the back end stops; the queue keeps taking characters until its four
// entries are full, then in_ready_o drops.
// Reset clears the position count, accumulator, error flags, queue pointers,
// output valid and status (not the result payload); no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module uuid_v4_text_parser_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  character_i,
  input  wire logic        last_char_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      uuid_high_o,
  output logic [63:0]      uuid_low_o,
  output logic [1:0]       status_o
);

  uvp_pkg::item_t front_item;
  uvp_pkg::item_t back_item;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic in_accept;
  logic [uvp_pkg::QueueCntW-1:0] q_count;

  assign in_ready_o = !q_full;
  assign in_accept  = in_valid_i && in_ready_o;

  // Front end: classify each character.
  uvp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .character_i (character_i),
    .last_char_i (last_char_i),
    .item_o      (front_item)
  );

  // Queue between front and back end.
  uvp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (back_item),
    .count_o (q_count)
  );

  // Back end: accumulate and produce the result.
  uvp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .item_i      (back_item),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .uuid_high_o (uuid_high_o),
    .uuid_low_o  (uuid_low_o),
    .status_o    (status_o)
  );

  // An error result never carries a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != uvp_pkg::STATUS_OK) |-> (uuid_high_o == '0 && uuid_low_o == '0))
    else $error("error result carries a non-zero value");

  // An ok result is version 4 with the RFC variant.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == uvp_pkg::STATUS_OK) |->
      (uuid_high_o[15:12] == uvp_pkg::VersionFour && uuid_low_o[63:62] == uvp_pkg::VariantRfc))
    else $error("ok result fails the version or variant check");

  // Queue occupancy stays within its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= uvp_pkg::QueueCntW'(uvp_pkg::QueueDepth))
    else $error("queue occupancy exceeds its depth");

  // A stalled result blocks the back end from taking entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !q_pop)
    else $error("back end popped while the result was stalled");

endmodule

`default_nettype wire

// File: design/uvp_front.sv
// ----------------------------------------------------------------------------
// uvp_front: character classifier
// Tracks the character position and turns each accepted character into a
// classified record for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module uvp_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [7:0]          character_i,
  input  wire logic                last_char_i,
  output uvp_pkg::item_t           item_o
);

  logic [uvp_pkg::PosW-1:0] pos_q, pos_d;
  logic is_dash_slot;
  logic in_text;
  logic is_digit;
  logic is_lower;

  // Position classification.
  assign in_text      = (pos_q < uvp_pkg::PosW'(uvp_pkg::TextLen));
  assign is_dash_slot = (pos_q == uvp_pkg::DashPos0) || (pos_q == uvp_pkg::DashPos1) ||
                        (pos_q == uvp_pkg::DashPos2) || (pos_q == uvp_pkg::DashPos3);

  // Character classification.
  assign is_digit = (character_i >= uvp_pkg::ChZero) && (character_i <= uvp_pkg::ChNine);
  assign is_lower = (character_i >= uvp_pkg::ChLowA) && (character_i <= uvp_pkg::ChLowF);

  always_comb begin
    item_o.shift    = in_text && !is_dash_slot;
    item_o.nibble   = is_digit ? character_i[3:0] :
                      is_lower ? (character_i[3:0] + 4'd9) : 4'd0;
    item_o.hex_bad  = in_text && !is_dash_slot && !is_digit && !is_lower;
    item_o.dash_bad = in_text && is_dash_slot && (character_i != uvp_pkg::ChDash);
    item_o.last     = last_char_i;
    item_o.len_ok   = (pos_q == uvp_pkg::PosW'(uvp_pkg::TextLen - 1));
  end

  // Saturating position count, cleared after the final character.
  always_comb begin
    pos_d = pos_q;
    if (accept_i) begin
      if (last_char_i) begin
        pos_d = '0;
      end else if (pos_q < uvp_pkg::PosW'(uvp_pkg::PosSat)) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

// File: design/uvp_queue.sv
// ----------------------------------------------------------------------------
// uvp_queue: short queue of classified characters
// A small register FIFO that decouples the classifier from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module uvp_queue (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire uvp_pkg::item_t               item_i,
  output logic                              full_o,
  input  wire logic                         pop_i,
  output logic                              valid_o,
  output uvp_pkg::item_t                    item_o,
  output logic [uvp_pkg::QueueCntW-1:0]     count_o
);

  uvp_pkg::item_t mem_q [uvp_pkg::QueueDepth];
  logic [uvp_pkg::QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [uvp_pkg::QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [uvp_pkg::QueueCntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == uvp_pkg::QueueCntW'(uvp_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// File: design/uvp_back.sv
// ----------------------------------------------------------------------------
// uvp_back: nibble accumulator and result stage
// Shifts nibbles into the 128-bit value, collects error flags and, on the
// final character, registers the value and status in the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module uvp_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  wire uvp_pkg::item_t item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [63:0]         uuid_high_o,
  output logic [63:0]         uuid_low_o,
  output logic [1:0]          status_o
);

  logic [63:0] acc_hi_q, acc_hi_d;
  logic [63:0] acc_lo_q, acc_lo_d;
  logic        dash_err_q, dash_err_d;
  logic        hex_err_q, hex_err_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_hi_q, out_hi_d;
  logic [63:0] out_lo_q, out_lo_d;
  uvp_pkg::status_e status_q, status_d;

  logic [63:0] new_hi, new_lo;
  logic        new_dash, new_hex;
  uvp_pkg::status_e res_status;

  // Take an entry whenever the output stage is free or being emptied.
  assign pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  // Value and flags including the current character.
  always_comb begin
    new_hi   = acc_hi_q;
    new_lo   = acc_lo_q;
    if (item_i.shift) begin
      new_hi = {acc_hi_q[59:0], acc_lo_q[63:60]};
      new_lo = {acc_lo_q[59:0], item_i.nibble};
    end
    new_dash = dash_err_q || item_i.dash_bad;
    new_hex  = hex_err_q || item_i.hex_bad;
  end

  // Status in order of priority.
  always_comb begin
    if (!item_i.len_ok || new_dash) begin
      res_status = uvp_pkg::STATUS_FORMAT;
    end else if (new_hex) begin
      res_status = uvp_pkg::STATUS_BAD_HEX;
    end else if ((new_hi == '0 && new_lo == '0) ||
                 (new_hi[15:12] != uvp_pkg::VersionFour) ||
                 (new_lo[63:62] != uvp_pkg::VariantRfc)) begin
      res_status = uvp_pkg::STATUS_NOT_V4;
    end else begin
      res_status = uvp_pkg::STATUS_OK;
    end
  end

  // Accumulator and output stage.
  always_comb begin
    acc_hi_d    = acc_hi_q;
    acc_lo_d    = acc_lo_q;
    dash_err_d  = dash_err_q;
    hex_err_d   = hex_err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_hi_d    = out_hi_q;
    out_lo_d    = out_lo_q;
    status_d    = status_q;
    if (pop_o) begin
      if (item_i.last) begin
        acc_hi_d    = '0;
        acc_lo_d    = '0;
        dash_err_d  = 1'b0;
        hex_err_d   = 1'b0;
        out_valid_d = 1'b1;
        status_d    = res_status;
        out_hi_d    = (res_status == uvp_pkg::STATUS_OK) ? new_hi : '0;
        out_lo_d    = (res_status == uvp_pkg::STATUS_OK) ? new_lo : '0;
      end else begin
        acc_hi_d   = new_hi;
        acc_lo_d   = new_lo;
        dash_err_d = new_dash;
        hex_err_d  = new_hex;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_hi_q    <= '0;
      acc_lo_q    <= '0;
      dash_err_q  <= 1'b0;
      hex_err_q   <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= uvp_pkg::STATUS_OK;
    end else begin
      acc_hi_q    <= acc_hi_d;
      acc_lo_q    <= acc_lo_d;
      dash_err_q  <= dash_err_d;
      hex_err_q   <= hex_err_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    out_hi_q <= out_hi_d;
    out_lo_q <= out_lo_d;
  end

  assign out_valid_o = out_valid_q;
  assign uuid_high_o = out_hi_q;
  assign uuid_low_o  = out_lo_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

// File: verif/tb_uuid_v4_text_parser_core.sv
// ----------------------------------------------------------------------------
// tb_uuid_v4_text_parser_core: self-checking bench for the UUID text parser
// Streams UUID texts into the parser one character per transaction. The texts
// are canonical version 4 strings with random content or arbitrary values, plus corrupted,
// uppercase, short, overlong and noise texts. A scoreboard tracks the parse
// state of each accepted character, predicts every result, and compares each
// result transaction field by field. Both channels idle in random bursts.
// ----------------------------------------------------------------------------

// Expected result of one complete text.
typedef struct {
  logic [63:0]       hi;
  logic [63:0]       lo;
  uvp_pkg::status_e  status;
} uuid_result_t;

// Tracks the parse state of the text in flight and holds the expected results.
class uuid_parse_tracker;
  logic [5:0]     pos;
  logic [127:0]   value;
  bit             dash_err;
  bit             hex_err;
  uuid_result_t   pending_uuids[$];
  int             mismatches;
  int             results_noted;

  function new();
    pos           = '0;
    value         = '0;
    dash_err      = 0;
    hex_err       = 0;
    mismatches    = 0;
    results_noted = 0;
  endfunction

  // Records one accepted character and, on the final one, predicts the result.
  function void note_char(logic [7:0] ch, logic last);
    logic [3:0]   nib;
    bit           dash_slot;
    uuid_result_t res;
    dash_slot = (pos == uvp_pkg::DashPos0) || (pos == uvp_pkg::DashPos1) ||
                (pos == uvp_pkg::DashPos2) || (pos == uvp_pkg::DashPos3);
    if (pos < uvp_pkg::TextLen) begin
      if (dash_slot) begin
        if (ch != uvp_pkg::ChDash) dash_err = 1;
      end else begin
        if (ch >= uvp_pkg::ChZero && ch <= uvp_pkg::ChNine) begin
          nib = 4'(ch - uvp_pkg::ChZero);
        end else if (ch >= uvp_pkg::ChLowA && ch <= uvp_pkg::ChLowF) begin
          nib = 4'(ch - uvp_pkg::ChLowA + 8'd10);
        end else begin
          // A character that is not a lowercase digit shifts in a zero nibble.
          nib     = 4'h0;
          hex_err = 1;
        end
        value = {value[123:0], nib};
      end
    end
    if (pos < uvp_pkg::PosSat) pos = pos + 6'd1;
    if (!last) return;

    // Format errors win over hex errors, which win over the version check.
    if (pos != uvp_pkg::TextLen || dash_err) begin
      res.status = uvp_pkg::STATUS_FORMAT;
    end else if (hex_err) begin
      res.status = uvp_pkg::STATUS_BAD_HEX;
    end else if (value == '0 || value[79:76] != uvp_pkg::VersionFour ||
                 value[63:62] != uvp_pkg::VariantRfc) begin
      res.status = uvp_pkg::STATUS_NOT_V4;
    end else begin
      res.status = uvp_pkg::STATUS_OK;
    end
    res.hi = (res.status == uvp_pkg::STATUS_OK) ? value[127:64] : 64'h0;
    res.lo = (res.status == uvp_pkg::STATUS_OK) ? value[63:0]   : 64'h0;
    pending_uuids.push_back(res);
    results_noted++;
    pos      = '0;
    value    = '0;
    dash_err = 0;
    hex_err  = 0;
  endfunction

  // Compares one result transaction with the oldest expectation.
  function void check_result(logic [63:0] hi, logic [63:0] lo, logic [1:0] status);
    uuid_result_t exp_res;
    if (pending_uuids.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected result hi=%h lo=%h status=%0d", hi, lo, status);
      return;
    end
    exp_res = pending_uuids.pop_front();
    if (hi !== exp_res.hi || lo !== exp_res.lo || status !== exp_res.status) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"ERROR: result mismatch: expected hi=%h lo=%h status=%0d, ",
                  "got hi=%h lo=%h status=%0d"},
                 exp_res.hi, exp_res.lo, exp_res.status, hi, lo, status);
    end
  endfunction

  function int pending();
    return pending_uuids.size();
  endfunction

  // Any expectation still waiting at the end is a failure.
  function void close_out();
    if (pending_uuids.size() != 0) begin
      mismatches++;
      $display("ERROR: %0d expected results never arrived", pending_uuids.size());
    end
  endfunction
endclass

module tb_uuid_v4_text_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TargetChars = 1400;
  localparam logic [7:0]  ChUpA       = 8'h41;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  character_i;
  logic        last_char_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] uuid_high_o;
  logic [63:0] uuid_low_o;
  logic [1:0]  status_o;

  uuid_parse_tracker tracker;
  logic [7:0]        text_q[$];
  int                chars_sent;
  bit                idle_on;
  int                send_gap_pct;

  uuid_v4_text_parser_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .character_i (character_i),
    .last_char_i (last_char_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .uuid_high_o (uuid_high_o),
    .uuid_low_o  (uuid_low_o),
    .status_o    (status_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Overall time limit.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? uvp_pkg::ChZero + 8'(n) : uvp_pkg::ChLowA + 8'(n) - 8'd10;
  endfunction

  // Maps the k-th hex digit (0 to 31) to its position in the text.
  function automatic int hex_slot(int k);
    return k + int'(k >= 8) + int'(k >= 12) + int'(k >= 16) + int'(k >= 20);
  endfunction

  function automatic logic [127:0] random_value();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [127:0] make_v4(logic [127:0] v);
    v[79:76] = uvp_pkg::VersionFour;
    v[63:62] = uvp_pkg::VariantRfc;
    return v;
  endfunction

  // Fills the text queue with the canonical form of a 128-bit value.
  task automatic build_text(logic [127:0] v);
    int k;
    k = 0;
    text_q.delete();
    for (int p = 0; p < 36; p++) begin
      if (p == 8 || p == 13 || p == 18 || p == 23) begin
        text_q.push_back(uvp_pkg::ChDash);
      end else begin
        text_q.push_back(hex_char(v[127 - 4*k -: 4]));
        k++;
      end
    end
  endtask

  // Cuts or extends the text to a given length with assorted characters.
  task automatic resize_text(int n);
    while (text_q.size() > n) void'(text_q.pop_back());
    while (text_q.size() < n) begin
      case ($urandom_range(0, 2))
        0:       text_q.push_back(hex_char(4'($urandom)));
        1:       text_q.push_back(uvp_pkg::ChDash);
        default: text_q.push_back(8'($urandom));
      endcase
    end
  endtask

  // Sends one character and waits until it is accepted.
  task automatic send_char(logic [7:0] ch, logic last);
    if (idle_on && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    character_i <= ch;
    last_char_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_char(ch, last);
    chars_sent++;
  endtask

  task automatic send_text();
    send_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
  endtask

  // One random text: well-formed version 4, arbitrary value, broken or noise.
  task automatic random_text();
    int sel;
    int p;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      build_text(make_v4(random_value()));
    end else if (sel < 60) begin
      build_text(($urandom_range(0, 9) == 0) ? 128'h0 : random_value());
    end else if (sel < 75) begin
      build_text(make_v4(random_value()));
      p = $urandom_range(0, 35);
      text_q[p] = 8'($urandom);
    end else if (sel < 83) begin
      build_text(make_v4(random_value()));
      text_q[hex_slot($urandom_range(0, 31))] = ChUpA + 8'($urandom_range(0, 5));
    end else if (sel < 95) begin
      build_text(make_v4(random_value()));
      p = $urandom_range(1, 44);
      resize_text((p == 36) ? 37 : p);
    end else begin
      text_q.delete();
      resize_text($urandom_range(1, 40));
    end
  endtask

  // Receiver: ready idles in random bursts while idling is enabled.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_result(uuid_high_o, uuid_low_o, status_o);
    end
  end

  // Main stimulus.
  initial begin
    int guard;
    tracker     = new();
    chars_sent  = 0;
    idle_on     = 1;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    character_i <= 8'h00;
    last_char_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed texts: valid extremes, each status and the priority cases.
    build_text(make_v4(random_value()));                          send_text();
    build_text(128'hffffffff_ffff_4fff_bfff_ffffffffffff);        send_text();
    build_text(128'h00000000_0000_4000_8000_000000000000);        send_text();
    build_text(128'h0);                                           send_text();
    build_text(128'h12345678_9abc_1def_8123_456789abcdef);        send_text();
    build_text(128'h12345678_9abc_4def_c123_456789abcdef);        send_text();
    build_text(make_v4(random_value()));
    text_q[hex_slot(3)] = ChUpA + 8'd5;                           send_text();
    build_text(make_v4(random_value()));
    text_q[hex_slot(0)] = uvp_pkg::ChDash;                        send_text();
    build_text(make_v4(random_value()));
    text_q[13] = uvp_pkg::ChZero;                                 send_text();
    text_q.delete();
    text_q.push_back(uvp_pkg::ChLowA);                            send_text();
    build_text(make_v4(random_value())); resize_text(35);         send_text();
    build_text(make_v4(random_value())); resize_text(37);         send_text();
    build_text(make_v4(random_value())); resize_text(45);         send_text();
    build_text(make_v4(random_value()));
    text_q[hex_slot(31)] = 8'hff;
    text_q[hex_slot(30)] = 8'h00;                                 send_text();
    build_text(make_v4(random_value()));
    text_q[23] = uvp_pkg::ChLowF;
    text_q[hex_slot(5)] = 8'h47;                                  send_text();
    build_text(128'h0);
    text_q[hex_slot(10)] = 8'h2f;                                 send_text();
    build_text(make_v4(random_value()));
    text_q[hex_slot(1)] = 8'h3a;
    text_q[hex_slot(2)] = 8'h60;
    text_q[hex_slot(4)] = 8'h67;                                  send_text();

    // Random texts; no idling in the final stretch.
    while (chars_sent < TargetChars) begin
      idle_on = (chars_sent < (TargetChars * 85) / 100);
      random_text();
      send_text();
    end
    in_valid_i <= 1'b0;

    // Drain the outstanding results, then allow for the output latency.
    guard = 0;
    while (tracker.pending() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    tracker.close_out();
    if (tracker.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
